[sv/ipfr_pkg.sv]
package ipfr_pkg;
    localparam int CONTEXTS = 16;
    localparam int HOLES = 8;
    localparam int CW = $clog2(CONTEXTS);
    localparam int HW = $clog2(HOLES);
    localparam int HOLE_DEPTH = CONTEXTS * HOLES;
    localparam int HAW = $clog2(HOLE_DEPTH);
    localparam int KEY_W = 88;
    localparam int CTX_W = KEY_W + 32 + 16;
    localparam logic [16:0] HDR_PLUS_ONE = 17'd61;
    localparam logic [12:0] OFFSET_MASK = 13'h1fff;

    localparam logic [2:0] ST_PENDING  = 3'd0;
    localparam logic [2:0] ST_COMPLETE = 3'd1;
    localparam logic [2:0] ST_FULL     = 3'd2;
    localparam logic [2:0] ST_BUFEXC   = 3'd3;
    localparam logic [2:0] ST_OVERFLOW = 3'd4;
    localparam logic [2:0] ST_TICK     = 3'd5;

    localparam logic REG_BUFFER_SIZE = 1'b0;
    localparam logic REG_TICKS = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_TICK_RD,
        S_TICK_CHK,
        S_SRCH_RD,
        S_SRCH_CHK,
        S_DECIDE,
        S_HOLE_RD,
        S_HOLE_PROC,
        S_HOLE_WR,
        S_FINISH,
        S_OUT
    } state_t;
endpackage

[sv/ipfr_ram.sv]
module ipfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

[sv/ip_fragment_reassembly_tracker.sv]
// channel  | dir | tdata fields (low bit up)                                   | tuser
// s_axis   | in  | source_addr, dest_addr, ident, protocol, frag_offset,       | operation
//          |     | more_fragments, payload_length, time_to_live (pad to 128b)  |
// m_axis   | out | status, slot, datagram_length, expired_mask (pad to 40b)    | -
// cfg      | in  | cfg_we, cfg_index (0 buffer_size, 1 ticks_per_ttl_unit)     | -
// a fragment reads and checks each context for the key search, decides, reads and processes
// each hole entry, writes back each new hole, then finishes and outputs; a tick reads and checks
// each context; both step one entry at a time through the single read port of each memory
// reset clears the valid bits and clock and loads the config defaults at once; no clearing pass
// the result sits in an output register until taken; the next request waits for that
module ip_fragment_reassembly_tracker
    import ipfr_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [127:0] s_axis_tdata,  // source_addr, dest_addr, ident, protocol,
                                        // frag_offset, more_fragments, payload_length,
                                        // time_to_live
    input  logic         s_axis_tuser,  // operation
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [39:0]  m_axis_tdata,  // status, slot, datagram_length, expired_mask
    input  logic         cfg_we,
    input  logic         cfg_index,
    input  logic [15:0]  cfg_data
);
    state_t state_reg, state_next;
    logic [15:0] bufsz_reg, ticks_reg;
    logic [31:0] clock_reg, clock_next;
    logic [CONTEXTS-1:0] cvalid_reg, cvalid_next;
    logic [HOLE_DEPTH-1:0] hvalid_reg, hvalid_next;

    logic op_reg, op_next;
    logic [KEY_W-1:0] key_reg, key_next;
    logic [16:0] ff_reg, ff_next;
    logic signed [18:0] fl_reg, fl_next;
    logic more_reg, more_next;
    logic [7:0] ttl_reg, ttl_next;
    logic [CW:0] ci_reg, ci_next;
    logic [CW-1:0] slot_reg, slot_next;
    logic found_reg, found_next;
    logic freef_reg, freef_next;
    logic [CW-1:0] free_reg, free_next;
    logic [15:0] mask_reg, mask_next;
    logic [15:0] total_reg, total_next;
    logic [HW:0] hi_reg, hi_next;
    logic [HW+1:0] n_reg, n_next;
    logic [HW+1:0] wi_reg, wi_next;
    logic [15:0] nf_reg [HOLES+1];
    logic [15:0] nl_reg [HOLES+1];
    logic [15:0] nf_next [HOLES+1];
    logic [15:0] nl_next [HOLES+1];
    logic [39:0] out_reg, out_next;
    logic ovalid_reg, ovalid_next;
    logic newctx_reg, newctx_next;
    logic [31:0] prod_reg;

    logic c_we;
    logic [CW-1:0] c_waddr, c_raddr;
    logic [CTX_W-1:0] c_wdata, c_rdata;
    logic h_we;
    logic [HAW-1:0] h_waddr, h_raddr;
    logic [31:0] h_wdata, h_rdata;

    ipfr_ram #(.WIDTH(CTX_W), .DEPTH(CONTEXTS)) u_ctx (
        .clk(clk), .we(c_we), .waddr(c_waddr), .wdata(c_wdata),
        .raddr(c_raddr), .rdata(c_rdata));
    ipfr_ram #(.WIDTH(32), .DEPTH(HOLE_DEPTH)) u_hole (
        .clk(clk), .we(h_we), .waddr(h_waddr), .wdata(h_wdata),
        .raddr(h_raddr), .rdata(h_rdata));

    assign s_axis_tready = (state_reg == S_IDLE) && !ovalid_reg;
    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata = out_reg;

    logic [HAW-1:0] hbase;
    assign hbase = HAW'(slot_reg) << HW;

    always_ff @(posedge clk)
    begin
        prod_reg <= 32'(ticks_reg) * 32'(ttl_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            bufsz_reg <= 16'd4096;
            ticks_reg <= 16'd200;
            clock_reg <= '0;
            cvalid_reg <= '0;
            hvalid_reg <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clock_reg <= clock_next;
            cvalid_reg <= cvalid_next;
            hvalid_reg <= hvalid_next;
            ovalid_reg <= ovalid_next;
            if (cfg_we && cfg_index == REG_BUFFER_SIZE)
            begin
                bufsz_reg <= cfg_data;
            end
            if (cfg_we && cfg_index == REG_TICKS)
            begin
                ticks_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg <= op_next;
        key_reg <= key_next;
        ff_reg <= ff_next;
        fl_reg <= fl_next;
        more_reg <= more_next;
        ttl_reg <= ttl_next;
        ci_reg <= ci_next;
        slot_reg <= slot_next;
        found_reg <= found_next;
        freef_reg <= freef_next;
        free_reg <= free_next;
        mask_reg <= mask_next;
        total_reg <= total_next;
        hi_reg <= hi_next;
        n_reg <= n_next;
        wi_reg <= wi_next;
        out_reg <= out_next;
        newctx_reg <= newctx_next;
        for (int i = 0; i <= HOLES; i++)
        begin
            nf_reg[i] <= nf_next[i];
            nl_reg[i] <= nl_next[i];
        end
    end

    logic signed [18:0] hf_s, hl_s, ff_s;
    logic [CW-1:0] cur;
    logic [HAW-1:0] hidx;

    always_comb
    begin
        state_next = state_reg;
        clock_next = clock_reg;
        cvalid_next = cvalid_reg;
        hvalid_next = hvalid_reg;
        ovalid_next = ovalid_reg;
        op_next = op_reg;
        key_next = key_reg;
        ff_next = ff_reg;
        fl_next = fl_reg;
        more_next = more_reg;
        ttl_next = ttl_reg;
        ci_next = ci_reg;
        slot_next = slot_reg;
        found_next = found_reg;
        freef_next = freef_reg;
        free_next = free_reg;
        mask_next = mask_reg;
        total_next = total_reg;
        hi_next = hi_reg;
        n_next = n_reg;
        wi_next = wi_reg;
        out_next = out_reg;
        newctx_next = newctx_reg;
        for (int i = 0; i <= HOLES; i++)
        begin
            nf_next[i] = nf_reg[i];
            nl_next[i] = nl_reg[i];
        end
        c_we = 1'b0;
        c_waddr = slot_reg;
        c_wdata = {total_reg, clock_reg + prod_reg, key_reg};
        c_raddr = ci_reg[CW-1:0];
        h_we = 1'b0;
        h_waddr = hbase | HAW'(wi_reg[HW-1:0]);
        h_wdata = {nl_reg[wi_reg[HW:0]], nf_reg[wi_reg[HW:0]]};
        hidx = hbase | HAW'(hi_reg[HW-1:0]);
        h_raddr = hidx;
        cur = ci_reg[CW-1:0];
        ff_s = 19'(ff_reg);
        hf_s = 19'(h_rdata[15:0]);
        hl_s = 19'(h_rdata[31:16]);

        if (m_axis_tvalid && m_axis_tready)
        begin
            ovalid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid && s_axis_tready)
                begin
                    op_next = s_axis_tuser;
                    key_next = {s_axis_tdata[79:64], s_axis_tdata[87:80],
                                s_axis_tdata[63:32], s_axis_tdata[31:0]};
                    ff_next = {1'b0, s_axis_tdata[100:88] & OFFSET_MASK, 3'b000};
                    more_next = s_axis_tdata[101];
                    fl_next = 19'(s_axis_tdata[100:88]) * 19'sd8
                            + 19'(s_axis_tdata[117:102]) - 19'sd1;
                    ttl_next = s_axis_tdata[125:118];
                    ci_next = '0;
                    mask_next = '0;
                    found_next = 1'b0;
                    freef_next = 1'b0;
                    if (s_axis_tuser)
                    begin
                        clock_next = clock_reg + 32'd1;
                        state_next = S_TICK_RD;
                    end
                    else
                    begin
                        state_next = S_SRCH_RD;
                    end
                end
            end
            S_TICK_RD:
            begin
                state_next = S_TICK_CHK;
            end
            S_TICK_CHK:
            begin
                if (cvalid_reg[cur] && !(c_rdata[KEY_W+31:KEY_W] > clock_reg))
                begin
                    cvalid_next[cur] = 1'b0;
                    for (int h = 0; h < HOLES; h++)
                    begin
                        hvalid_next[(HAW'(cur) << HW) | HAW'(h)] = 1'b0;
                    end
                    mask_next[cur] = 1'b1;
                end
                if (ci_reg == (CW+1)'(CONTEXTS - 1))
                begin
                    out_next = {1'b0, mask_next, 16'd0, 4'd0, ST_TICK};
                    state_next = S_OUT;
                end
                else
                begin
                    ci_next = ci_reg + 1'b1;
                    state_next = S_TICK_RD;
                end
            end
            S_SRCH_RD:
            begin
                state_next = S_SRCH_CHK;
            end
            S_SRCH_CHK:
            begin
                if (cvalid_reg[cur] && c_rdata[KEY_W-1:0] == key_reg && !found_reg)
                begin
                    found_next = 1'b1;
                    slot_next = cur;
                    total_next = c_rdata[CTX_W-1:CTX_W-16];
                end
                if (!cvalid_reg[cur] && !freef_reg)
                begin
                    freef_next = 1'b1;
                    free_next = cur;
                end
                if (ci_reg == (CW+1)'(CONTEXTS - 1))
                begin
                    state_next = S_DECIDE;
                end
                else
                begin
                    ci_next = ci_reg + 1'b1;
                    state_next = S_SRCH_RD;
                end
            end
            S_DECIDE:
            begin
                newctx_next = !found_reg;
                if (!found_reg && !freef_reg)
                begin
                    out_next = {1'b0, 16'd0, 16'd0, 4'd0, ST_FULL};
                    state_next = S_OUT;
                end
                else
                begin
                    if (!found_reg)
                    begin
                        slot_next = free_reg;
                        total_next = bufsz_reg;
                    end
                    if ($signed({3'b000, bufsz_reg}) < fl_reg + 19'sd61)
                    begin
                        cvalid_next[slot_next] = 1'b0;
                        for (int h = 0; h < HOLES; h++)
                        begin
                            hvalid_next[(HAW'(slot_next) << HW) | HAW'(h)] = 1'b0;
                        end
                        out_next = {1'b0, 16'd0, 16'd0, 4'(slot_next), ST_BUFEXC};
                        state_next = S_OUT;
                    end
                    else
                    begin
                        if (!more_reg)
                        begin
                            total_next = 16'(fl_reg + 19'sd61);
                        end
                        hi_next = '0;
                        n_next = '0;
                        state_next = S_HOLE_RD;
                    end
                end
            end
            S_HOLE_RD:
            begin
                state_next = S_HOLE_PROC;
            end
            S_HOLE_PROC:
            begin
                if (newctx_reg)
                begin
                    if (hi_reg == '0)
                    begin
                        hf_s = '0;
                        hl_s = 19'(16'(bufsz_reg - 16'd61));
                    end
                end
                if ((newctx_reg && hi_reg == '0) || (!newctx_reg && hvalid_reg[hidx]))
                begin
                    if (ff_s > hl_s || fl_reg < hf_s)
                    begin
                        nf_next[n_next[HW:0]] = hf_s[15:0];
                        nl_next[n_next[HW:0]] = hl_s[15:0];
                        n_next = n_next + 1'b1;
                    end
                    else
                    begin
                        if (ff_s > hf_s && n_next <= (HW+2)'(HOLES))
                        begin
                            nf_next[n_next[HW:0]] = hf_s[15:0];
                            nl_next[n_next[HW:0]] = 16'(ff_s - 19'sd1);
                            n_next = n_next + 1'b1;
                        end
                        if (more_reg && fl_reg < hl_s && n_next <= (HW+2)'(HOLES))
                        begin
                            nf_next[n_next[HW:0]] = 16'(fl_reg + 19'sd1);
                            nl_next[n_next[HW:0]] = hl_s[15:0];
                            n_next = n_next + 1'b1;
                        end
                    end
                end
                if (hi_reg == (HW+1)'(HOLES - 1))
                begin
                    wi_next = '0;
                    state_next = S_HOLE_WR;
                    if (n_next > (HW+2)'(HOLES) || n_next == '0)
                    begin
                        state_next = S_FINISH;
                    end
                end
                else
                begin
                    hi_next = hi_reg + 1'b1;
                    state_next = S_HOLE_RD;
                end
            end
            S_HOLE_WR:
            begin
                h_we = 1'b1;
                hvalid_next[h_waddr] = 1'b1;
                if (wi_reg == n_reg - 1'b1)
                begin
                    state_next = S_FINISH;
                end
                wi_next = wi_reg + 1'b1;
            end
            S_FINISH:
            begin
                for (int h = 0; h < HOLES; h++)
                begin
                    if ((HW+2)'(h) >= n_reg || n_reg > (HW+2)'(HOLES))
                    begin
                        hvalid_next[hbase | HAW'(h)] = 1'b0;
                    end
                end
                if (n_reg > (HW+2)'(HOLES))
                begin
                    cvalid_next[slot_reg] = 1'b0;
                    out_next = {1'b0, 16'd0, 16'd0, 4'(slot_reg), ST_OVERFLOW};
                end
                else if (n_reg == '0)
                begin
                    cvalid_next[slot_reg] = 1'b0;
                    out_next = {1'b0, 16'd0, total_reg, 4'(slot_reg), ST_COMPLETE};
                end
                else
                begin
                    c_we = 1'b1;
                    cvalid_next[slot_reg] = 1'b1;
                    out_next = {1'b0, 16'd0, 16'd0, 4'(slot_reg), ST_PENDING};
                end
                state_next = S_OUT;
            end
            S_OUT:
            begin
                ovalid_next = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end
endmodule

[tb/sv/tb_top.sv]
module tb_top
    import ipfr_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 150;
    localparam int KEY_POOL = 20;

    typedef struct packed {
        logic [1:0]  pad;
        logic [7:0]  time_to_live;
        logic [15:0] payload_length;
        logic        more_fragments;
        logic [12:0] frag_offset;
        logic [7:0]  protocol;
        logic [15:0] ident;
        logic [31:0] dest_addr;
        logic [31:0] source_addr;
    } frag_t;

    typedef struct packed {
        logic        pad;
        logic [15:0] expired_mask;
        logic [15:0] datagram_length;
        logic [3:0]  slot;
        logic [2:0]  status;
    } result_t;

    typedef struct {
        logic    op;
        frag_t   f;
        bit      typed;
        result_t exp;
    } stim_row_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [127:0] s_axis_tdata = '0;  // source_addr, dest_addr, ident, protocol,
                                      // frag_offset, more_fragments, payload_length,
                                      // time_to_live
    logic         s_axis_tuser = 1'b0;  // operation
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [39:0]  m_axis_tdata;  // status, slot, datagram_length, expired_mask
    logic         cfg_we = 1'b0;
    logic         cfg_index = 1'b0;
    logic [15:0]  cfg_data = '0;

    ip_fragment_reassembly_tracker u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    // tracker model state
    logic [15:0] buf_size = 16'd4096;
    logic [15:0] ttl_ticks = 16'd200;
    logic [31:0] now_ticks = '0;
    logic        ctx_valid [CONTEXTS];
    logic [31:0] ctx_src [CONTEXTS];
    logic [31:0] ctx_dst [CONTEXTS];
    logic [23:0] ctx_idp [CONTEXTS];
    logic [31:0] ctx_expire [CONTEXTS];
    logic [15:0] ctx_total [CONTEXTS];
    logic        hole_v [CONTEXTS][HOLES];
    logic [15:0] hole_f [CONTEXTS][HOLES];
    logic [15:0] hole_l [CONTEXTS][HOLES];

    result_t pending_results [$];
    int errors = 0;
    int idle_cycles = 0;
    int send_idle_pct = 22;
    int recv_idle_pct = 78;
    int items_sent = 0;
    frag_t key_pool [KEY_POOL];

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    task automatic drop_ctx(input int c);
        ctx_valid[c] = 1'b0;
        for (int h = 0; h < HOLES; h++)
            hole_v[c][h] = 1'b0;
    endtask

    task automatic track_fragment(input logic op, input frag_t f, output result_t r);
        int ffirst;
        int flast;
        int c;
        int n;
        int hf;
        int hl;
        bit found;
        logic [15:0] mask;
        logic [31:0] tmp;
        logic [15:0] nf [20];
        logic [15:0] nl [20];
        r = '0;
        if (op)
        begin
            now_ticks = now_ticks + 32'd1;
            mask = '0;
            for (int i = 0; i < CONTEXTS; i++)
                if (ctx_valid[i] && !(ctx_expire[i] > now_ticks))
                begin
                    drop_ctx(i);
                    mask[i] = 1'b1;
                end
            r.status = ST_TICK;
            r.expired_mask = mask;
            return;
        end
        ffirst = int'(f.frag_offset) * 8;
        flast = ffirst + int'(f.payload_length) - 1;
        found = 0;
        c = 0;
        for (int i = 0; i < CONTEXTS; i++)
            if (!found && ctx_valid[i] && ctx_src[i] == f.source_addr &&
                ctx_dst[i] == f.dest_addr && ctx_idp[i] == {f.ident, f.protocol})
            begin
                found = 1;
                c = i;
            end
        if (!found)
        begin
            for (int i = 0; i < CONTEXTS; i++)
                if (!found && !ctx_valid[i])
                begin
                    found = 1;
                    c = i;
                end
            if (!found)
            begin
                r.status = ST_FULL;
                return;
            end
            ctx_valid[c] = 1'b1;
            ctx_src[c] = f.source_addr;
            ctx_dst[c] = f.dest_addr;
            ctx_idp[c] = {f.ident, f.protocol};
            ctx_total[c] = buf_size;
            for (int h = 0; h < HOLES; h++)
                hole_v[c][h] = 1'b0;
            tmp = {16'd0, buf_size} - 32'd61;
            hole_v[c][0] = 1'b1;
            hole_f[c][0] = '0;
            hole_l[c][0] = tmp[15:0];
        end
        r.slot = c[3:0];
        if (int'(buf_size) < flast + 61)
        begin
            drop_ctx(c);
            r.status = ST_BUFEXC;
            return;
        end
        ctx_expire[c] = now_ticks + {16'd0, ttl_ticks} * {24'd0, f.time_to_live};
        if (!f.more_fragments)
            ctx_total[c] = 16'(flast + 61);
        n = 0;
        for (int h = 0; h < HOLES; h++)
        begin
            if (hole_v[c][h])
            begin
                hf = int'(hole_f[c][h]);
                hl = int'(hole_l[c][h]);
                if (ffirst > hl || flast < hf)
                begin
                    nf[n] = hf[15:0];
                    nl[n] = hl[15:0];
                    n++;
                end
                else
                begin
                    if (ffirst > hf && n <= HOLES)
                    begin
                        nf[n] = hf[15:0];
                        nl[n] = 16'(ffirst - 1);
                        n++;
                    end
                    if (f.more_fragments && flast < hl && n <= HOLES)
                    begin
                        nf[n] = 16'(flast + 1);
                        nl[n] = hl[15:0];
                        n++;
                    end
                end
            end
        end
        if (n > HOLES)
        begin
            drop_ctx(c);
            r.status = ST_OVERFLOW;
            return;
        end
        for (int h = 0; h < HOLES; h++)
        begin
            hole_v[c][h] = (h < n);
            if (h < n)
            begin
                hole_f[c][h] = nf[h];
                hole_l[c][h] = nl[h];
            end
        end
        if (n == 0)
        begin
            r.status = ST_COMPLETE;
            r.datagram_length = ctx_total[c];
            drop_ctx(c);
            return;
        end
        r.status = ST_PENDING;
    endtask

    function automatic frag_t make_frag(logic [31:0] src, logic [31:0] dst, logic [15:0] id,
                                        logic [7:0] pr, logic [12:0] off, logic mf,
                                        logic [15:0] len, logic [7:0] ttl);
        frag_t f;
        f = '0;
        f.source_addr = src;
        f.dest_addr = dst;
        f.ident = id;
        f.protocol = pr;
        f.frag_offset = off;
        f.more_fragments = mf;
        f.payload_length = len;
        f.time_to_live = ttl;
        return f;
    endfunction

    function automatic stim_row_t make_row(logic op, frag_t f, bit typed, logic [2:0] st,
                                           logic [3:0] sl, logic [15:0] dl, logic [15:0] mk);
        stim_row_t row;
        row.op = op;
        row.f = f;
        row.typed = typed;
        row.exp = '0;
        row.exp.status = st;
        row.exp.slot = sl;
        row.exp.datagram_length = dl;
        row.exp.expired_mask = mk;
        return row;
    endfunction

    task automatic send_request(input logic op, input frag_t f, output result_t r);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= f;
        s_axis_tuser <= op;
        @(negedge clk);
        while (!s_axis_tready)
            @(negedge clk);
        @(posedge clk);
        items_sent++;
        if (items_sent < 140)
        begin
            send_idle_pct = 22;
            recv_idle_pct = 78;
        end
        else if (items_sent < 280)
        begin
            send_idle_pct = 78;
            recv_idle_pct = 22;
        end
        else
        begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
        end
        track_fragment(op, f, r);
    endtask

    task automatic send_and_track(input logic op, input frag_t f);
        result_t r;
        send_request(op, f, r);
        pending_results.push_back(r);
    endtask

    task automatic write_reg(input logic idx, input logic [15:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        if (idx == REG_BUFFER_SIZE)
            buf_size = val;
        else
            ttl_ticks = val;
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic send_datagram();
        frag_t base;
        frag_t pieces [$];
        frag_t p;
        int avail;
        int total;
        int units;
        int pos;
        int take;
        int j;
        base = key_pool[$urandom_range(0, KEY_POOL - 1)];
        avail = (buf_size >= 61) ? int'(buf_size) - 60 : 0;
        if (avail == 0)
        begin
            send_and_track(1'b0, make_frag(base.source_addr, base.dest_addr, base.ident,
                                           base.protocol, 13'd0, 1'b0, 16'd8, 8'd10));
            return;
        end
        total = $urandom_range(1, (avail < 64) ? avail : 64);
        units = (total + 7) / 8;
        pos = 0;
        while (pos < units)
        begin
            take = $urandom_range(1, units - pos);
            p = make_frag(base.source_addr, base.dest_addr, base.ident, base.protocol,
                          13'(pos), 1'b1, 16'(take * 8), 8'($urandom_range(1, 255)));
            if (pos + take == units)
            begin
                p.more_fragments = 1'b0;
                p.payload_length = 16'(total - pos * 8);
            end
            pieces.push_back(p);
            pos += take;
        end
        pieces.shuffle();
        while (pieces.size() != 0)
        begin
            if ($urandom_range(0, 9) == 0)
                send_and_track(1'b1, frag_t'({$urandom, $urandom, $urandom, $urandom}));
            j = $urandom_range(0, 19) == 0 ? 1 : 0;
            p = pieces.pop_front();
            if (j == 1)
                p.frag_offset = 13'($urandom_range(0, 8));
            send_and_track(1'b0, p);
        end
    endtask

    always @(posedge clk)
        m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);

    always @(negedge clk)
    begin
        result_t got;
        result_t exp;
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = m_axis_tdata;
                if (pending_results.size() == 0)
                begin
                    $display("%0t unexpected result: expected none, actual %h", $time, got);
                    errors++;
                end
                else
                begin
                    exp = pending_results.pop_front();
                    if (got.status !== exp.status)
                    begin
                        $display("%0t status: expected %0d actual %0d", $time,
                                 exp.status, got.status);
                        errors++;
                    end
                    if (got.slot !== exp.slot)
                    begin
                        $display("%0t slot: expected %0d actual %0d", $time,
                                 exp.slot, got.slot);
                        errors++;
                    end
                    if (got.datagram_length !== exp.datagram_length)
                    begin
                        $display("%0t datagram_length: expected %0d actual %0d", $time,
                                 exp.datagram_length, got.datagram_length);
                        errors++;
                    end
                    if (got.expired_mask !== exp.expired_mask)
                    begin
                        $display("%0t expired_mask: expected %h actual %h", $time,
                                 exp.expired_mask, got.expired_mask);
                        errors++;
                    end
                end
            end
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    initial
    begin
        stim_row_t rows [$];
        result_t r;
        logic [15:0] phase_buf [6];
        logic [15:0] phase_ticks [6];
        int roll;
        for (int i = 0; i < CONTEXTS; i++)
        begin
            ctx_valid[i] = 1'b0;
            for (int h = 0; h < HOLES; h++)
                hole_v[i][h] = 1'b0;
        end

        rows.push_back(make_row(1'b1, '0, 1'b1, ST_TICK, 4'd0, 16'd0, 16'd0));
        rows.push_back(make_row(1'b0, make_frag(32'h0a000001, 32'h0a000002, 16'h1234, 8'd17,
                                13'd0, 1'b1, 16'd8, 8'd1), 1'b1, ST_PENDING, 4'd0, 16'd0,
                                16'd0));
        rows.push_back(make_row(1'b0, make_frag(32'h0a000001, 32'h0a000002, 16'h1234, 8'd17,
                                13'd1, 1'b0, 16'd8, 8'd1), 1'b1, ST_COMPLETE, 4'd0, 16'd76,
                                16'd0));
        rows.push_back(make_row(1'b0, make_frag('1, '1, '1, '1, OFFSET_MASK, 1'b0, '1, '1),
                                1'b1, ST_BUFEXC, 4'd0, 16'd0, 16'd0));
        // zero length payload
        rows.push_back(make_row(1'b0, make_frag(32'h1, 32'h2, 16'h3, 8'd6, 13'd0, 1'b1,
                                16'd0, 8'd255), 1'b0, '0, '0, '0, '0));
        rows.push_back(make_row(1'b0, make_frag('0, '0, '0, '0, 13'd0, 1'b0, '1, 8'd0), 1'b1,
                                ST_BUFEXC, 4'd1, 16'd0, 16'd0));
        // ttl of zero expires on the next tick
        rows.push_back(make_row(1'b0, make_frag(32'h5, 32'h6, 16'h7, 8'd1, 13'd2, 1'b1,
                                16'd8, 8'd0), 1'b0, '0, '0, '0, '0));
        rows.push_back(make_row(1'b1, '0, 1'b0, '0, '0, '0, '0));
        // hole table overflow
        for (int k = 0; k < 8; k++)
            rows.push_back(make_row(1'b0, make_frag(32'hc0a80001, 32'hc0a80002, 16'h00aa, 8'd6,
                                    13'(2 * k + 1), 1'b1, 16'd8, 8'd10), 1'b0, '0, '0, '0,
                                    '0));
        // last fragment arrives first, tail of the hole dropped
        rows.push_back(make_row(1'b0, make_frag(32'h9, 32'h8, 16'hbeef, 8'd17, 13'd4, 1'b0,
                                16'd8, 8'd20), 1'b0, '0, '0, '0, '0));
        rows.push_back(make_row(1'b0, make_frag(32'h9, 32'h8, 16'hbeef, 8'd17, 13'd0, 1'b1,
                                16'd32, 8'd20), 1'b0, '0, '0, '0, '0));
        rows.push_back(make_row(1'b1, frag_t'({4{32'hffffffff}}), 1'b0, '0, '0, '0, '0));

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i])
        begin
            send_request(rows[i].op, rows[i].f, r);
            pending_results.push_back(rows[i].typed ? rows[i].exp : r);
        end
        drain_results();

        phase_buf[0] = 16'd4096;  phase_ticks[0] = 16'd200;
        phase_buf[1] = 16'd61;    phase_ticks[1] = 16'd1;
        phase_buf[2] = 16'hffff;  phase_ticks[2] = 16'hffff;
        phase_buf[3] = 16'($urandom_range(100, 1500));  phase_ticks[3] = 16'd0;
        phase_buf[4] = 16'd0;     phase_ticks[4] = 16'($urandom_range(1, 3));
        phase_buf[5] = 16'($urandom_range(61, 700));   phase_ticks[5] = 16'($urandom);

        for (int ph = 0; ph < 6; ph++)
        begin
            write_reg(REG_BUFFER_SIZE, phase_buf[ph]);
            write_reg(REG_TICKS, phase_ticks[ph]);
            for (int k = 0; k < KEY_POOL; k++)
                key_pool[k] = make_frag($urandom, $urandom, 16'($urandom), 8'($urandom),
                                        '0, 1'b0, '0, '0);
            for (int n = 0; n < ((ph == 4) ? 20 : 40); n++)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 65)
                    send_datagram();
                else if (roll < 85)
                    send_and_track(1'b1, frag_t'({$urandom, $urandom, $urandom, $urandom}));
                else
                    send_and_track(1'b0, frag_t'({$urandom, $urandom, $urandom, $urandom}));
            end
            drain_results();
        end

        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
